/* rtl/core/chd_pkg.sv */
// Shared constants, command codes and control/status types for the canonical Huffman decoder.
package chd_pkg;

  localparam int CMD_W    = 2;
  localparam int SYM_W    = 8;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;

  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_NUM_SYMBOLS  = 256;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic shift;
    logic check;
    logic take;
    logic flush;
  } chd_cmd_t;

  typedef struct packed {
    logic found;
    logic bit_last;
    logic held_valid;
    logic out_free;
  } chd_status_t;

endpackage

/* rtl/core/chd_if.sv */
// Valid/ready channel interfaces for decoder input items and result items.
interface chd_in_if import chd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [SYM_W-1:0] symbol;
  logic [LEN_W-1:0] code_length;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, command, symbol, code_length, data_byte, input ready);
  modport sink   (input valid, command, symbol, code_length, data_byte, output ready);
endinterface

interface chd_out_if import chd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] decoded_symbol;
  logic             error;
  logic             last;

  modport source (output valid, decoded_symbol, error, last, input ready);
  modport sink   (input valid, decoded_symbol, error, last, output ready);
endinterface

/* rtl/core/chd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module chd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/chd_ctrl.sv */
// Controller state machine: sequences commands and the per-bit decode steps.
module chd_ctrl import chd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] command,
  output logic             in_ready,
  input  chd_status_t      status,
  output chd_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_TAKE  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_CLEAR: cmd.clear = 1'b1;
            CMD_LOAD:  cmd.load  = 1'b1;
            CMD_DATA: begin
              cmd.start  = 1'b1;
              state_next = S_SHIFT;
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.found) begin
          state_next = S_TAKE;
        end else if (status.bit_last) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_TAKE: begin
        // hold while the previous result cannot move to the output register
        if (!status.held_valid || status.out_free) begin
          cmd.take   = 1'b1;
          state_next = status.bit_last ? S_FLUSH : S_SHIFT;
        end
      end
      S_FLUSH: begin
        if (!status.held_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/chd_dp.sv */
// Datapath: code table, symbol store, pending bits, match logic and result registers.
module chd_dp import chd_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS
) (
  input  logic              clk,
  input  logic              rst,
  input  chd_cmd_t          cmd,
  output chd_status_t       status,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [LEN_W-1:0]  code_length,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [SYM_W-1:0]  decoded_symbol,
  output logic              error,
  output logic              last
);

  localparam int CODE_W = MAX_CODE_LEN;
  localparam int LW     = $clog2(MAX_CODE_LEN + 1);
  localparam int AW     = $clog2(MAX_CODE_LEN);
  localparam int IW     = $clog2(NUM_SYMBOLS);
  localparam int CW     = $clog2(NUM_SYMBOLS + 1);
  localparam int ROW_W  = CW + CODE_W + IW;
  localparam int OW     = (CODE_W > CW) ? CODE_W : CW;
  localparam int BCW    = $clog2(BYTE_W + 1);

  // table builder state
  logic [CW-1:0]       entries;
  logic [CODE_W:0]     next_code;
  logic [LW-1:0]       cur_len;
  logic [CW-1:0]       cur_count;
  logic [CODE_W-1:0]   cur_first_code;
  logic [IW-1:0]       cur_first_index;
  logic [MAX_CODE_LEN-1:0] row_valid;

  // decode state
  logic [CODE_W-1:0]   pending;
  logic [LW-1:0]       plen;
  logic [BYTE_W-1:0]   byte_reg;
  logic [BCW-1:0]      bit_cnt;
  logic                row_vld_q;
  logic                res_err;
  logic                held_valid;
  logic [SYM_W-1:0]    held_sym;
  logic                held_err;

  // load path
  logic [LW-1:0]       ld_len;
  logic [LW-1:0]       shift_amt;
  logic [CODE_W-1:0]   cand;
  logic [CODE_W:0]     cur_limit;
  logic                load_ok;
  logic                same_row;
  logic [AW-1:0]       row_waddr;
  logic [ROW_W-1:0]    row_wdata;

  // match path
  logic [ROW_W-1:0]    row_q;
  logic [CW-1:0]       row_cnt;
  logic [CODE_W-1:0]   row_first;
  logic [IW-1:0]       row_index;
  logic [CODE_W-1:0]   off;
  logic                hit;
  logic                overrun;
  logic [IW-1:0]       sym_raddr;
  logic [SYM_W-1:0]    sym_q;

  assign ld_len    = code_length[LW-1:0];
  assign shift_amt = ld_len - cur_len;
  assign cand      = next_code[CODE_W-1:0] << shift_amt;
  assign cur_limit = {{CODE_W{1'b0}}, 1'b1} << cur_len;
  assign same_row  = (ld_len == cur_len);
  assign row_waddr = AW'(ld_len - 1'b1);

  assign load_ok = cmd.load
                && (code_length != '0)
                && (code_length <= LEN_W'(MAX_CODE_LEN))
                && (code_length >= LEN_W'(cur_len))
                && (entries < CW'(NUM_SYMBOLS))
                && (next_code < cur_limit);

  assign row_wdata = same_row ? {cur_count + 1'b1, cur_first_code, cur_first_index}
                              : {CW'(1), cand, entries[IW-1:0]};

  chd_ram #(.WIDTH(ROW_W), .DEPTH(MAX_CODE_LEN)) u_table (
    .clk   (clk),
    .we    (load_ok),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (cmd.shift),
    .raddr (plen[AW-1:0]),
    .rdata (row_q)
  );

  assign {row_cnt, row_first, row_index} = row_q;
  assign off       = pending - row_first;
  assign hit       = row_vld_q && (row_cnt != '0) && (pending >= row_first)
                  && (OW'(off) < OW'(row_cnt));
  assign overrun   = !hit && (plen == LW'(MAX_CODE_LEN));
  assign sym_raddr = row_index + off[IW-1:0];

  chd_ram #(.WIDTH(SYM_W), .DEPTH(NUM_SYMBOLS)) u_symbols (
    .clk   (clk),
    .we    (load_ok),
    .waddr (entries[IW-1:0]),
    .wdata (symbol),
    .re    (cmd.check && hit),
    .raddr (sym_raddr),
    .rdata (sym_q)
  );

  assign status.found      = hit || overrun;
  assign status.bit_last   = (bit_cnt == BCW'(BYTE_W));
  assign status.held_valid = held_valid;
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries    <= '0;
      next_code  <= '0;
      cur_len    <= '0;
      cur_count  <= '0;
      row_valid  <= '0;
      pending    <= '0;
      plen       <= '0;
      bit_cnt    <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // load the output register, or drop its item once taken
      if ((cmd.take && held_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        entries   <= '0;
        next_code <= '0;
        cur_len   <= '0;
        row_valid <= '0;
        pending   <= '0;
        plen      <= '0;
      end
      if (load_ok) begin
        entries              <= entries + 1'b1;
        next_code            <= {1'b0, cand} + 1'b1;
        cur_len              <= ld_len;
        cur_count            <= same_row ? cur_count + 1'b1 : CW'(1);
        row_valid[row_waddr] <= 1'b1;
      end
      if (cmd.start) begin
        bit_cnt <= '0;
      end
      if (cmd.shift) begin
        pending <= {pending[CODE_W-2:0], byte_reg[BYTE_W-1]};
        plen    <= plen + 1'b1;
        bit_cnt <= bit_cnt + 1'b1;
      end
      // drop the pending bits once they form a code or overrun the longest one
      if (cmd.check && (hit || overrun)) begin
        pending <= '0;
        plen    <= '0;
      end
      if (cmd.take) begin
        held_valid <= 1'b1;
      end
      if (cmd.flush) begin
        held_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_ok && !same_row) begin
      cur_first_code  <= cand;
      cur_first_index <= entries[IW-1:0];
    end
    if (cmd.start) begin
      byte_reg <= data_byte;
    end
    if (cmd.shift) begin
      byte_reg  <= byte_reg << 1;
      row_vld_q <= row_valid[plen[AW-1:0]];
    end
    if (cmd.check) begin
      res_err <= !hit;
    end
    if (cmd.take) begin
      if (held_valid) begin
        decoded_symbol <= held_sym;
        error          <= held_err;
        last           <= 1'b0;
      end
      held_sym <= res_err ? '0 : sym_q;
      held_err <= res_err;
    end
    if (cmd.flush) begin
      decoded_symbol <= held_sym;
      error          <= held_err;
      last           <= 1'b1;
    end
  end

endmodule

/* rtl/core/canonical_huffman_decoder_unit.sv */
// Canonical Huffman decoder top level: controller, datapath and channel ports.
// Clear and load items finish in their accept cycle; a load appends one (symbol, length) entry in
// canonical order and writes its length's row of the code table. A data byte is decoded one
// bit at a time, MSB first: each bit is shifted in, then compared against the table row
// read from the code-table RAM for the new pending length. A bit that completes a code, or
// leaves MAX_CODE_LEN bits pending with no match (an error result), adds a take step that
// captures the result; take and final flush steps wait while the output is stalled.
// Each result is held back one step so that the final result of a byte carries last; the
// next item is accepted as soon as the byte's last result sits in the output register.
module canonical_huffman_decoder_unit import chd_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS
) (
  input logic       clk,
  input logic       rst,
  chd_in_if.sink    din,
  chd_out_if.source dout
);

  chd_cmd_t    cmd;
  chd_status_t status;

  chd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .command  (din.command),
    .in_ready (din.ready),
    .status   (status),
    .cmd      (cmd)
  );

  chd_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .symbol         (din.symbol),
    .code_length    (din.code_length),
    .data_byte      (din.data_byte),
    .out_ready      (dout.ready),
    .out_valid      (dout.valid),
    .decoded_symbol (dout.decoded_symbol),
    .error          (dout.error),
    .last           (dout.last)
  );

endmodule
